@@ rtl/bpk_pkg.sv @@
package bpk_pkg;

	// byte geometry of the output stream
	localparam int BYTE_W = 8;
	localparam int OFF_W  = 3;
	localparam int AVL_W  = 4;

	// one result request as held in the output register
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_req_t;

	// handshake between the front queue and the back packer
	typedef struct packed {
		logic valid;
		logic flush;
	} head_ctl_t;

endpackage

@@ rtl/bpk_front.sv @@
module bpk_front #(
	parameter int VALUE_WIDTH = 64,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	output logic                   stall,
	input  logic [VALUE_WIDTH-1:0] field_value,
	input  logic [6:0]             bit_count,
	input  logic                   flush,
	output bpk_pkg::head_ctl_t     head_ctl,
	output logic [VALUE_WIDTH-1:0] head_value,
	output logic [CNT_W-1:0]       head_count,
	input  logic                   pop
);

	localparam int DEPTH = 2;

	logic [CNT_W-1:0]       cnt_sat;
	logic [VALUE_WIDTH-1:0] val_aligned;
	logic [VALUE_WIDTH-1:0] val_q   [DEPTH];
	logic [CNT_W-1:0]       cnt_q   [DEPTH];
	logic                   flush_q [DEPTH];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             fill_q;
	logic                   push;
	logic                   do_pop;

	// saturate the count and left-align the field so its first bit is the MSB
	always_comb begin
		if (bit_count > 7'(VALUE_WIDTH)) begin
			cnt_sat = CNT_W'(VALUE_WIDTH);
		end else begin
			cnt_sat = CNT_W'(bit_count);
		end
		val_aligned = field_value << (CNT_W'(VALUE_WIDTH) - cnt_sat);
	end

	assign stall  = (fill_q == 2'(DEPTH));
	assign push   = valid && !stall;
	assign do_pop = pop && (fill_q != 2'd0);

	// two-entry request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_ptr_q]   <= val_aligned;
			cnt_q[wr_ptr_q]   <= cnt_sat;
			flush_q[wr_ptr_q] <= flush;
		end
	end

	assign head_ctl.valid = (fill_q != 2'd0);
	assign head_ctl.flush = flush_q[rd_ptr_q];
	assign head_value     = val_q[rd_ptr_q];
	assign head_count     = cnt_q[rd_ptr_q];

endmodule

@@ rtl/bpk_back.sv @@
module bpk_back #(
	parameter int VALUE_WIDTH = 64,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpk_pkg::head_ctl_t     head_ctl,
	input  logic [VALUE_WIDTH-1:0] head_value,
	input  logic [CNT_W-1:0]       head_count,
	output logic                   pop,
	output logic                   valid,
	input  logic                   stall,
	output bpk_pkg::out_req_t      res
);

	// current request being packed
	logic                       cur_valid_q;
	logic [VALUE_WIDTH-1:0]     cur_val_q;
	logic [CNT_W-1:0]           cur_rem_q;
	logic                       cur_flush_q;
	// packer state
	logic [bpk_pkg::BYTE_W-1:0] part_q;
	logic [bpk_pkg::OFF_W-1:0]  off_q;
	// output register
	logic                       out_valid_q;
	bpk_pkg::out_req_t          out_q;

	logic [bpk_pkg::AVL_W-1:0]  avail;
	logic [bpk_pkg::BYTE_W-1:0] top8;
	logic [bpk_pkg::BYTE_W-1:0] tail_bits;
	logic [bpk_pkg::BYTE_W-1:0] merged;
	logic [CNT_W-1:0]           rem_next;
	logic                       full_path;
	logic                       emit;
	logic                       done;
	logic                       step;
	logic                       out_free;
	bpk_pkg::out_req_t          emit_req;
	logic [bpk_pkg::BYTE_W-1:0] part_d;
	logic [bpk_pkg::OFF_W-1:0]  off_d;

	// one step: fill the partial byte from the top of the aligned field
	always_comb begin
		avail     = bpk_pkg::AVL_W'(bpk_pkg::BYTE_W) - {1'b0, off_q};
		top8      = cur_val_q[VALUE_WIDTH-1 -: bpk_pkg::BYTE_W];
		full_path = (cur_rem_q >= CNT_W'(avail));
		rem_next  = cur_rem_q - CNT_W'(avail);
		tail_bits = top8 & ~(8'hFF >> cur_rem_q[2:0]);
		merged    = part_q | (tail_bits >> off_q);
		part_d    = part_q;
		off_d     = off_q;
		emit      = 1'b0;
		done      = 1'b0;
		emit_req.out_byte = part_q | (top8 >> off_q);
		emit_req.last     = 1'b0;
		if (full_path) begin
			// a byte completes
			emit   = 1'b1;
			part_d = '0;
			off_d  = '0;
			done   = (rem_next == '0);
			emit_req.last = (rem_next < CNT_W'(bpk_pkg::BYTE_W))
				&& !(cur_flush_q && (rem_next != '0));
		end else begin
			// request ends inside the partial byte
			done  = 1'b1;
			off_d = off_q + cur_rem_q[2:0];
			if (cur_flush_q) begin
				emit   = (off_d != '0);
				part_d = '0;
				off_d  = '0;
				emit_req.out_byte = merged;
				emit_req.last     = 1'b1;
			end else begin
				part_d = merged;
			end
		end
	end

	assign out_free = !out_valid_q || !stall;
	assign step     = cur_valid_q && (!emit || out_free);
	assign pop      = head_ctl.valid && (!cur_valid_q || (step && done));

	// current request and packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			part_q      <= '0;
			off_q       <= '0;
		end else begin
			if (step) begin
				part_q <= part_d;
				off_q  <= off_d;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (step && done) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_val_q   <= head_value;
			cur_rem_q   <= head_count;
			cur_flush_q <= head_ctl.flush;
		end else if (step && full_path) begin
			cur_val_q <= cur_val_q << avail;
			cur_rem_q <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= emit_req;
		end
	end

	assign valid = out_valid_q;
	assign res   = out_q;

endmodule

@@ rtl/msb_first_bit_packer.sv @@
// MSB-first bit packer.
// Input channel (in_valid/in_stall): each request carries field_value, bit_count
// and flush. The low bit_count bits of field_value (count saturated to
// VALUE_WIDTH) are appended to the stream, highest bit first; flush then pads
// the pending partial byte with zeros, sends it, and clears the packer.
// Output channel (out_valid/out_stall): one packed byte per transfer, earliest
// bit in bit 7; last marks the final byte produced by an input request.
// Throughput: at most one byte per cycle from the packer while out_stall is low;
// a request takes one step per byte completed from its field, plus one more
// when it ends inside the partial byte (bits left over, nothing completed,
// or a flush padding byte), so up to 9 steps for a 64-bit field with flush.
// A two-entry queue in front of the packer absorbs requests
// while it works, and the output register lets the packer run while a byte
// waits. When out_stall is high the held byte stays put and the packer halts
// on its next byte; the queue then fills and in_stall rises.
// Reset clears the queue, the output register and the partial byte.
module msb_first_bit_packer #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] field_value,
	input  logic [6:0]             bit_count,
	input  logic                   flush,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   last
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	bpk_pkg::head_ctl_t     head_ctl;
	logic [VALUE_WIDTH-1:0] head_value;
	logic [CNT_W-1:0]       head_count;
	logic                   pop;
	bpk_pkg::out_req_t      res;

	// request queue
	bpk_front #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.CNT_W       (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (in_valid),
		.stall       (in_stall),
		.field_value (field_value),
		.bit_count   (bit_count),
		.flush       (flush),
		.head_ctl    (head_ctl),
		.head_value  (head_value),
		.head_count  (head_count),
		.pop         (pop)
	);

	// byte packer
	bpk_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.CNT_W       (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_ctl   (head_ctl),
		.head_value (head_value),
		.head_count (head_count),
		.pop        (pop),
		.valid      (out_valid),
		.stall      (out_stall),
		.res        (res)
	);

	assign out_byte = res.out_byte;
	assign last     = res.last;

endmodule

@@ tb/sv/msb_first_bit_packer_test.sv @@
`timescale 1ns / 100ps

module msb_first_bit_packer_test;

	localparam int VALUE_W = 64;
	localparam logic [63:0] ALL1 = {64{1'b1}};
	localparam logic KNOWN = 1'b1;
	localparam logic MODEL = 1'b0;
	localparam int NUM_DIRECTED = 22;
	localparam int NUM_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 87;
	localparam int MAX_REPORTS = 10;

	// directed row: request fields plus, where obvious, the bytes it must give
	// (first byte in the highest occupied position of 'bytes')
	typedef struct packed {
		logic [63:0] value;
		logic [6:0]  count;
		logic        flush;
		logic        known;
		logic [3:0]  n_bytes;
		logic [71:0] bytes;
	} field_row_t;

	localparam field_row_t DIRECTED [NUM_DIRECTED] = '{
		'{64'hA5,                  7'd8,   1'b0, KNOWN, 4'd1, 72'hA5},
		'{ALL1,                    7'd64,  1'b0, KNOWN, 4'd8, 72'hFFFF_FFFF_FFFF_FFFF},
		'{64'h0,                   7'd64,  1'b0, KNOWN, 4'd8, 72'h0},
		// zero count appends nothing
		'{64'hDEAD_BEEF,           7'd0,   1'b0, KNOWN, 4'd0, 72'h0},
		// flush on an empty partial byte sends nothing
		'{ALL1,                    7'd0,   1'b1, KNOWN, 4'd0, 72'h0},
		'{64'h1,                   7'd1,   1'b1, KNOWN, 4'd1, 72'h80},
		// oversized counts saturate to the full width
		'{64'h0123_4567_89AB_CDEF, 7'd127, 1'b0, KNOWN, 4'd8, 72'h0123_4567_89AB_CDEF},
		'{ALL1,                    7'd65,  1'b0, KNOWN, 4'd8, 72'hFFFF_FFFF_FFFF_FFFF},
		'{64'h5,                   7'd3,   1'b0, KNOWN, 4'd0, 72'h0},
		'{64'h1F,                  7'd5,   1'b0, KNOWN, 4'd1, 72'hBF},
		'{64'h3,                   7'd2,   1'b0, KNOWN, 4'd0, 72'h0},
		'{ALL1,                    7'd64,  1'b1, MODEL, 4'd0, 72'h0},
		'{64'hFFFF_0000_0000_1234, 7'd13,  1'b1, MODEL, 4'd0, 72'h0},
		'{64'h8000_0000_0000_0001, 7'd64,  1'b1, KNOWN, 4'd8, 72'h8000_0000_0000_0001},
		'{64'h7F,                  7'd7,   1'b1, KNOWN, 4'd1, 72'hFE},
		'{64'h7F,                  7'd7,   1'b0, KNOWN, 4'd0, 72'h0},
		'{ALL1,                    7'd57,  1'b1, MODEL, 4'd0, 72'h0},
		// one leading bit, then a full field with flush: nine bytes
		'{64'h0,                   7'd1,   1'b0, KNOWN, 4'd0, 72'h0},
		'{ALL1,                    7'd64,  1'b1, MODEL, 4'd0, 72'h0},
		// flush alone sends the pending bit
		'{64'h1,                   7'd1,   1'b0, KNOWN, 4'd0, 72'h0},
		'{64'hFFFF,                7'd0,   1'b1, KNOWN, 4'd1, 72'h80},
		'{64'h0,                   7'd96,  1'b1, KNOWN, 4'd8, 72'h0}
	};

	localparam int IDLE_PCT [NUM_PHASES]  = '{0, 78, 0, 32};
	localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 78, 32};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] field_value = '0;
	logic [6:0]         bit_count = '0;
	logic               flush = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_byte;
	logic               last;

	// side info traveling with the request being offered
	logic               row_known = 1'b0;
	logic [3:0]         row_n = '0;
	logic [71:0]        row_bytes = '0;

	int                 idle_pct = 0;
	int                 stall_pct = 0;
	int                 mismatch_cnt = 0;

	// packer state as predicted
	logic [7:0]         acc_byte = '0;
	logic [2:0]         acc_fill = '0;

	bpk_pkg::out_req_t  pending_bytes[$];

	msb_first_bit_packer #(
		.VALUE_WIDTH(VALUE_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.field_value(field_value),
		.bit_count  (bit_count),
		.flush      (flush),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// append one field MSB first, optionally flush; returns bytes completed
	function automatic int pack_field(input logic [63:0] v, input logic [6:0] cnt,
			input logic f, output logic [8:0][7:0] bytes);
		int n;
		int nbits;
		n = 0;
		bytes = '0;
		nbits = (int'(cnt) > VALUE_W) ? VALUE_W : int'(cnt);
		for (int i = nbits - 1; i >= 0; i--) begin
			acc_byte[7 - acc_fill] = v[i];
			if (acc_fill == 3'd7) begin
				bytes[n] = acc_byte;
				n++;
				acc_byte = '0;
				acc_fill = '0;
			end else begin
				acc_fill = acc_fill + 3'd1;
			end
		end
		if (f) begin
			if (acc_fill != 3'd0) begin
				bytes[n] = acc_byte;
				n++;
			end
			acc_byte = '0;
			acc_fill = '0;
		end
		return n;
	endfunction

	task automatic log_mismatch(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
	endtask

	// check completed bytes, then record what a newly accepted request owes
	always @(posedge clk) begin : monitor
		logic [8:0][7:0]   pred;
		int                n;
		bpk_pkg::out_req_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_bytes.size() == 0) begin
					log_mismatch("unexpected byte", 8'h00, out_byte);
				end else begin
					exp_r = pending_bytes.pop_front();
					if (out_byte !== exp_r.out_byte)
						log_mismatch("out_byte", exp_r.out_byte, out_byte);
					if (last !== exp_r.last)
						log_mismatch("last", {7'd0, exp_r.last}, {7'd0, last});
				end
			end
			if (in_valid && !in_stall) begin
				n = pack_field(field_value, bit_count, flush, pred);
				if (row_known) begin
					for (int k = 0; k < int'(row_n); k++) begin
						exp_r.out_byte = row_bytes[8 * (int'(row_n) - 1 - k) +: 8];
						exp_r.last = (k == int'(row_n) - 1);
						pending_bytes.push_back(exp_r);
					end
				end else begin
					for (int k = 0; k < n; k++) begin
						exp_r.out_byte = pred[k];
						exp_r.last = (k == n - 1);
						pending_bytes.push_back(exp_r);
					end
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// offer one request and hold it until accepted
	task automatic send_field(input logic [63:0] v, input logic [6:0] cnt, input logic f,
			input logic known, input logic [3:0] n, input logic [71:0] bytes);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		field_value <= v;
		bit_count   <= cnt;
		flush       <= f;
		row_known   <= known;
		row_n       <= n;
		row_bytes   <= bytes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random_field();
		logic [63:0] v;
		logic [6:0]  cnt;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 6)
			v = ALL1;
		else if (pick < 10)
			v = '0;
		else if (pick < 16)
			v = 64'h1 << $urandom_range(63);
		else
			v = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 8)
			cnt = 7'd64;
		else if (pick < 14)
			cnt = 7'($urandom_range(127, 65));
		else if (pick < 20)
			cnt = 7'd0;
		else if (pick < 35)
			cnt = 7'($urandom_range(63, 25));
		else
			cnt = 7'($urandom_range(24, 1));
		send_field(v, cnt, ($urandom_range(99) < 18), MODEL, 4'd0, 72'h0);
	endtask

	// sender holds off until the block has given every byte owed
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int r = 0; r < NUM_DIRECTED; r++)
			send_field(DIRECTED[r].value, DIRECTED[r].count, DIRECTED[r].flush,
				DIRECTED[r].known, DIRECTED[r].n_bytes, DIRECTED[r].bytes);
		wait_drained();

		// random requests under each idling and backpressure mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct  = IDLE_PCT[p];
			stall_pct = STALL_PCT[p];
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_random_field();
			wait_drained();
		end

		// let any stray bytes show up
		stall_pct = 0;
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && pending_bytes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
